>>> rtl/csf_pkg.sv
// ----------------------------------------------------------------------------
// csf_pkg - conservative smoothing filter shared definitions
// Window geometry, field widths, register codes, word types and helpers.
// ----------------------------------------------------------------------------
package csf_pkg;

  localparam int unsigned WINDOW_SIZE = 3;
  localparam int unsigned MAX_WIDTH   = 2048;
  localparam int unsigned HALF        = WINDOW_SIZE / 2;

  localparam int unsigned CHAN_W      = 8;
  localparam int unsigned NUM_CHAN    = 3;
  localparam int unsigned CFG_W       = 12;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned MIN_SIZE    = 3;
  localparam int unsigned RESET_WIDTH  = 640;
  localparam int unsigned RESET_HEIGHT = 480;

  localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W  = CFG_W;
  localparam int unsigned BANK_W = $clog2(WINDOW_SIZE);
  localparam int unsigned EXT_W  = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
  localparam int unsigned DLY_W  = $clog2(HALF * (1 << CFG_W) + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'd1;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_PAD   = 1'b1;

  typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] pixel_t;
  typedef pixel_t [WINDOW_SIZE-1:0]        column_t;
  typedef column_t [WINDOW_SIZE-1:0]       window_t;

  typedef struct packed {
    logic              we;
    logic [BANK_W-1:0] wbank;
    logic [COL_W-1:0]  waddr;
    logic              re;
    logic [COL_W-1:0]  raddr;
  } ls_req_t;

  // bank of the line d rows above a line held in bank b
  function automatic logic [BANK_W-1:0] bank_back(input logic [BANK_W-1:0] b,
                                                  input int unsigned d);
    int unsigned t;
    t = 32'(b) + WINDOW_SIZE - d;
    if (t >= WINDOW_SIZE) t = t - WINDOW_SIZE;
    return BANK_W'(t);
  endfunction

endpackage

>>> rtl/conservative_smoothing_filter_top.sv
// ----------------------------------------------------------------------------
// conservative_smoothing_filter_top - streaming conservative smoothing filter
// Raster pixel stream in, each channel of interior pixels clamped to its window neighbours.
//
// channel  handshake                 words
// in       in_valid_i / in_stall_o   req_type_i chan0_i chan1_i chan2_i
// out      out_valid_o / out_stall_i out_chan0_o out_chan1_o out_chan2_o
//                                    end_of_frame_o
// cfg      cfg_we_i                  cfg_index_i cfg_data_i
//
// one word per cycle sustained unless out_stall_i holds the flow, set by the
// single read and write port of each line store bank; a word passes through
// stage one into the output register, results lag by half a window each way.
// reset clears counters and handshake state; the line store is not cleared.
// out_stall_i holds the output register and backs up to in_stall_o in the
// same cycle only when the stage in between holds a result.
// ----------------------------------------------------------------------------
module conservative_smoothing_filter_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          req_type_i,
  input  logic [csf_pkg::CHAN_W-1:0]    chan0_i,
  input  logic [csf_pkg::CHAN_W-1:0]    chan1_i,
  input  logic [csf_pkg::CHAN_W-1:0]    chan2_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [csf_pkg::CHAN_W-1:0]    out_chan0_o,
  output logic [csf_pkg::CHAN_W-1:0]    out_chan1_o,
  output logic [csf_pkg::CHAN_W-1:0]    out_chan2_o,
  output logic                          end_of_frame_o,
  input  logic                          cfg_we_i,
  input  logic [csf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [csf_pkg::CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned WIN    = csf_pkg::WINDOW_SIZE;
  localparam int unsigned HALF   = csf_pkg::HALF;
  localparam int unsigned COL_W  = csf_pkg::COL_W;
  localparam int unsigned ROW_W  = csf_pkg::ROW_W;
  localparam int unsigned BANK_W = csf_pkg::BANK_W;
  localparam int unsigned EXT_W  = csf_pkg::EXT_W;
  localparam int unsigned DLY_W  = csf_pkg::DLY_W;
  localparam int unsigned CFG_W  = csf_pkg::CFG_W;

  // configuration
  logic [CFG_W-1:0] width_q, width_d, height_q, height_d;
  logic [EXT_W-1:0] eff_w;
  logic [ROW_W-1:0] eff_h;
  logic [DLY_W-1:0] delay_v;
  logic             cfg_restart;

  // position counters
  logic [COL_W-1:0]  in_col_q, in_col_d, out_col_q, out_col_d;
  logic [ROW_W-1:0]  in_row_q, in_row_d, out_row_q, out_row_d;
  logic [BANK_W-1:0] in_bank_q, in_bank_d, out_bank_q, out_bank_d;
  logic [DLY_W-1:0]  lead_q, lead_d;

  // input side decode
  logic              in_accept, is_pixel, restart, enter;
  logic [COL_W-1:0]  cur_in_col, cur_out_col, nxt_in_col, nxt_out_col;
  logic [ROW_W-1:0]  cur_in_row, cur_out_row, nxt_in_row, nxt_out_row;
  logic [BANK_W-1:0] cur_in_bank, cur_out_bank, nxt_in_bank, nxt_out_bank;
  logic [DLY_W-1:0]  cur_lead;
  logic              in_wrap, out_wrap, lead_full, done_after;
  logic              emit, from_mem, interior, eof;

  // stage one
  logic                  s1_valid_q, s1_valid_d, s1_go;
  logic                  s1_pixel_q, s1_emit_q, s1_from_mem_q, s1_interior_q, s1_eof_q;
  logic [BANK_W-1:0]     s1_bank_q;
  csf_pkg::pixel_t       s1_pix_q;

  // line store and window
  csf_pkg::ls_req_t                ls_req;
  csf_pkg::pixel_t                 in_pix;
  csf_pkg::pixel_t [WIN-1:0]       rd_data;
  csf_pkg::column_t                new_col;
  csf_pkg::window_t                win_q, new_win;
  csf_pkg::pixel_t                 clamp_pix, res_pix;

  // output register
  logic                  out_valid_q, out_valid_d, out_load_ok, out_load;
  csf_pkg::pixel_t       out_pix_q;
  logic                  out_eof_q;

  // effective frame size
  always_comb begin
    eff_w = EXT_W'(width_q);
    if (eff_w < EXT_W'(csf_pkg::MIN_SIZE)) eff_w = EXT_W'(csf_pkg::MIN_SIZE);
    if (eff_w > EXT_W'(csf_pkg::MAX_WIDTH)) eff_w = EXT_W'(csf_pkg::MAX_WIDTH);
    eff_h = (height_q < CFG_W'(csf_pkg::MIN_SIZE)) ? ROW_W'(csf_pkg::MIN_SIZE) : height_q;
    delay_v = DLY_W'(eff_w) * DLY_W'(HALF) + DLY_W'(HALF);
  end

  // handshake
  assign out_load_ok = !out_valid_q || !out_stall_i;
  assign s1_go       = s1_valid_q && (!s1_emit_q || out_load_ok);
  assign in_stall_o  = s1_valid_q && !s1_go;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign is_pixel    = (req_type_i == csf_pkg::REQ_PIXEL);

  // item decode against the position counters
  always_comb begin
    restart      = is_pixel && (in_row_q >= eff_h);
    cur_in_col   = restart ? '0 : in_col_q;
    cur_in_row   = restart ? '0 : in_row_q;
    cur_in_bank  = restart ? '0 : in_bank_q;
    cur_lead     = restart ? '0 : lead_q;
    cur_out_col  = restart ? '0 : out_col_q;
    cur_out_row  = restart ? '0 : out_row_q;
    cur_out_bank = restart ? '0 : out_bank_q;

    in_wrap     = (EXT_W'(cur_in_col) + EXT_W'(1)) >= eff_w;
    nxt_in_col  = in_wrap ? '0 : cur_in_col + COL_W'(1);
    nxt_in_row  = in_wrap ? cur_in_row + ROW_W'(1) : cur_in_row;
    nxt_in_bank = in_wrap ? csf_pkg::bank_back(cur_in_bank, WIN - 1) : cur_in_bank;

    out_wrap     = (EXT_W'(cur_out_col) + EXT_W'(1)) >= eff_w;
    nxt_out_col  = out_wrap ? '0 : cur_out_col + COL_W'(1);
    nxt_out_row  = out_wrap ? cur_out_row + ROW_W'(1) : cur_out_row;
    nxt_out_bank = out_wrap ? csf_pkg::bank_back(cur_out_bank, WIN - 1) : cur_out_bank;

    lead_full  = (cur_lead == delay_v);
    done_after = is_pixel ? (nxt_in_row >= eff_h) : (in_row_q >= eff_h);
    emit       = done_after ? (cur_out_row < eff_h) : (is_pixel && lead_full);
    from_mem   = emit && !(is_pixel && lead_full);

    interior = (cur_out_row >= ROW_W'(HALF)) &&
               ((ROW_W+1)'(cur_out_row) + (ROW_W+1)'(HALF) < (ROW_W+1)'(eff_h)) &&
               (cur_out_col >= COL_W'(HALF)) &&
               (EXT_W'(cur_out_col) + EXT_W'(HALF) < eff_w);
    eof      = ((ROW_W+1)'(cur_out_row) + (ROW_W+1)'(1) == (ROW_W+1)'(eff_h)) &&
               out_wrap;
  end

  assign enter = in_accept && (is_pixel || emit);

  // counter and register updates
  always_comb begin
    width_d     = width_q;
    height_d    = height_q;
    cfg_restart = 1'b0;
    in_col_d    = in_col_q;
    in_row_d    = in_row_q;
    in_bank_d   = in_bank_q;
    lead_d      = lead_q;
    out_col_d   = out_col_q;
    out_row_d   = out_row_q;
    out_bank_d  = out_bank_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        csf_pkg::CFG_WIDTH: begin
          width_d     = cfg_data_i;
          cfg_restart = 1'b1;
        end
        csf_pkg::CFG_HEIGHT: begin
          height_d    = cfg_data_i;
          cfg_restart = 1'b1;
        end
        default: begin
          cfg_restart = 1'b0;
        end
      endcase
      if (cfg_restart) begin
        in_col_d   = '0;
        in_row_d   = '0;
        in_bank_d  = '0;
        lead_d     = '0;
        out_col_d  = '0;
        out_row_d  = '0;
        out_bank_d = '0;
      end
    end else if (in_accept) begin
      if (is_pixel) begin
        in_col_d   = nxt_in_col;
        in_row_d   = nxt_in_row;
        in_bank_d  = nxt_in_bank;
        lead_d     = lead_full ? cur_lead : cur_lead + DLY_W'(1);
        out_col_d  = cur_out_col;
        out_row_d  = cur_out_row;
        out_bank_d = cur_out_bank;
      end
      if (emit) begin
        out_col_d  = nxt_out_col;
        out_row_d  = nxt_out_row;
        out_bank_d = nxt_out_bank;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= CFG_W'(csf_pkg::RESET_WIDTH);
      height_q   <= CFG_W'(csf_pkg::RESET_HEIGHT);
      in_col_q   <= '0;
      in_row_q   <= '0;
      in_bank_q  <= '0;
      lead_q     <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      out_bank_q <= '0;
    end else begin
      width_q    <= width_d;
      height_q   <= height_d;
      in_col_q   <= in_col_d;
      in_row_q   <= in_row_d;
      in_bank_q  <= in_bank_d;
      lead_q     <= lead_d;
      out_col_q  <= out_col_d;
      out_row_q  <= out_row_d;
      out_bank_q <= out_bank_d;
    end
  end

  // line store access
  assign in_pix[0] = chan0_i;
  assign in_pix[1] = chan1_i;
  assign in_pix[2] = chan2_i;

  always_comb begin
    ls_req.we    = in_accept && is_pixel;
    ls_req.wbank = cur_in_bank;
    ls_req.waddr = cur_in_col;
    ls_req.re    = in_accept;
    ls_req.raddr = from_mem ? cur_out_col : cur_in_col;
  end

  csf_line_store u_line_store (
    .clk_i   (clk_i),
    .req_i   (ls_req),
    .wdata_i (in_pix),
    .rdata_o (rd_data)
  );

  // stage one
  assign s1_valid_d = enter ? 1'b1 : (s1_go ? 1'b0 : s1_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enter) begin
      s1_pixel_q    <= is_pixel;
      s1_emit_q     <= emit;
      s1_from_mem_q <= from_mem;
      s1_interior_q <= interior;
      s1_eof_q      <= eof;
      s1_bank_q     <= from_mem ? cur_out_bank : cur_in_bank;
      s1_pix_q      <= in_pix;
    end
  end

  // window shift
  always_comb begin
    for (int i = 0; i < WIN - 1; i++) begin
      new_col[i] = rd_data[csf_pkg::bank_back(s1_bank_q, WIN - 1 - i)];
    end
    new_col[WIN-1] = s1_pix_q;
    new_win[0] = new_col;
    for (int j = 1; j < WIN; j++) begin
      new_win[j] = win_q[j-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_pixel_q) begin
      win_q <= new_win;
    end
  end

  csf_clamp u_clamp (
    .win_i (new_win),
    .pix_o (clamp_pix)
  );

  always_comb begin
    if (s1_from_mem_q) begin
      res_pix = rd_data[s1_bank_q];
    end else if (s1_interior_q) begin
      res_pix = clamp_pix;
    end else begin
      res_pix = new_win[HALF][HALF];
    end
  end

  // output register
  assign out_load    = s1_go && s1_emit_q;
  assign out_valid_d = out_load ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_pix_q <= res_pix;
      out_eof_q <= s1_eof_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_chan0_o    = out_pix_q[0];
  assign out_chan1_o    = out_pix_q[1];
  assign out_chan2_o    = out_pix_q[2];
  assign end_of_frame_o = out_eof_q;

endmodule

>>> rtl/csf_line_store.sv
// ----------------------------------------------------------------------------
// csf_line_store - banked line store
// One bank per window row, each written at one address and read at one
// address per cycle, read data registered and held while not read.
// ----------------------------------------------------------------------------
module csf_line_store (
  input  logic                                       clk_i,
  input  csf_pkg::ls_req_t                           req_i,
  input  csf_pkg::pixel_t                            wdata_i,
  output csf_pkg::pixel_t [csf_pkg::WINDOW_SIZE-1:0] rdata_o
);

  for (genvar b = 0; b < csf_pkg::WINDOW_SIZE; b++) begin : g_bank
    csf_pkg::pixel_t mem [csf_pkg::MAX_WIDTH];
    csf_pkg::pixel_t rd_q;

    always_ff @(posedge clk_i) begin
      if (req_i.we && (req_i.wbank == csf_pkg::BANK_W'(b))) begin
        mem[req_i.waddr] <= wdata_i;
      end
      if (req_i.re) begin
        rd_q <= mem[req_i.raddr];
      end
    end

    assign rdata_o[b] = rd_q;
  end

endmodule

>>> rtl/csf_clamp.sv
// ----------------------------------------------------------------------------
// csf_clamp - neighbour clamp
// Clamps the window centre of each channel to the minimum and maximum of
// its neighbours, centre excluded.
// ----------------------------------------------------------------------------
module csf_clamp (
  input  csf_pkg::window_t win_i,
  output csf_pkg::pixel_t  pix_o
);

  logic [csf_pkg::NUM_CHAN-1:0][csf_pkg::WINDOW_SIZE-1:0][csf_pkg::CHAN_W-1:0] col_lo;
  logic [csf_pkg::NUM_CHAN-1:0][csf_pkg::WINDOW_SIZE-1:0][csf_pkg::CHAN_W-1:0] col_hi;
  logic [csf_pkg::NUM_CHAN-1:0][csf_pkg::CHAN_W-1:0] lo;
  logic [csf_pkg::NUM_CHAN-1:0][csf_pkg::CHAN_W-1:0] hi;

  // per column extremes
  always_comb begin
    for (int c = 0; c < csf_pkg::NUM_CHAN; c++) begin
      for (int j = 0; j < csf_pkg::WINDOW_SIZE; j++) begin
        col_lo[c][j] = '1;
        col_hi[c][j] = '0;
        for (int i = 0; i < csf_pkg::WINDOW_SIZE; i++) begin
          if (!((j == csf_pkg::HALF) && (i == csf_pkg::HALF))) begin
            if (win_i[j][i][c] < col_lo[c][j]) col_lo[c][j] = win_i[j][i][c];
            if (win_i[j][i][c] > col_hi[c][j]) col_hi[c][j] = win_i[j][i][c];
          end
        end
      end
    end
  end

  // across columns, then clamp
  always_comb begin
    for (int c = 0; c < csf_pkg::NUM_CHAN; c++) begin
      lo[c] = '1;
      hi[c] = '0;
      for (int j = 0; j < csf_pkg::WINDOW_SIZE; j++) begin
        if (col_lo[c][j] < lo[c]) lo[c] = col_lo[c][j];
        if (col_hi[c][j] > hi[c]) hi[c] = col_hi[c][j];
      end
      if (win_i[csf_pkg::HALF][csf_pkg::HALF][c] < lo[c]) begin
        pix_o[c] = lo[c];
      end else if (win_i[csf_pkg::HALF][csf_pkg::HALF][c] > hi[c]) begin
        pix_o[c] = hi[c];
      end else begin
        pix_o[c] = win_i[csf_pkg::HALF][csf_pkg::HALF][c];
      end
    end
  end

endmodule

>>> rtl/csf_checker.sv
// ----------------------------------------------------------------------------
// csf_checker - port level checks for the conservative smoothing filter
// Watches the stream handshakes of the top level and is bound to it.
// ----------------------------------------------------------------------------
module csf_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [csf_pkg::CHAN_W-1:0] out_chan0_o,
  input logic [csf_pkg::CHAN_W-1:0] out_chan1_o,
  input logic [csf_pkg::CHAN_W-1:0] out_chan2_o,
  input logic                       end_of_frame_o
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_chan0_o) &&
    $stable(out_chan1_o) && $stable(out_chan2_o) && $stable(end_of_frame_o))
    else $error("stalled result word changed");

  // input backs up only behind a stalled full output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled output");

  // a result appearing on an empty output came from an input word taken through stage one
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result word without a matching input word");

  // clean start after reset
  a_reset_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o && !in_stall_o)
    else $error("handshake busy right after reset");

endmodule

bind conservative_smoothing_filter_top csf_checker u_csf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .out_chan0_o    (out_chan0_o),
  .out_chan1_o    (out_chan1_o),
  .out_chan2_o    (out_chan2_o),
  .end_of_frame_o (end_of_frame_o)
);

>>> tb/conservative_smoothing_filter_top_test.sv
// ----------------------------------------------------------------------------
// conservative_smoothing_filter_top_test - self-checking bench for the filter
// Streams raster frames of random pixels and padding words through the block
// with random gaps and output stalls, tracks line store and counters in a
// scoreboard that clamps each interior pixel to its window neighbours, and
// compares every filtered word field by field in order.
// ----------------------------------------------------------------------------
module conservative_smoothing_filter_top_test;
  import csf_pkg::*;

  localparam int unsigned RANDOM_WORDS = 1550;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned QUIET_CYCLES = 8;

  typedef struct packed {
    pixel_t pix;
    logic   last;
  } filtered_word_t;

  typedef enum int unsigned { FILL_ANY, FILL_BAND, FILL_RAIL } fill_e;

  class smoothing_tracker;
    pixel_t         line_mem [WINDOW_SIZE][MAX_WIDTH];
    int unsigned    img_w, img_h;
    int unsigned    in_col, in_line, out_col, out_line;
    int unsigned    errors;
    filtered_word_t filtered_due[$];

    function new();
      img_w  = RESET_WIDTH;
      img_h  = RESET_HEIGHT;
      errors = 0;
      restart_frame();
    endfunction

    function void restart_frame();
      in_col   = 0;
      in_line  = 0;
      out_col  = 0;
      out_line = 0;
      filtered_due.delete();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_WIDTH:  img_w = val;
        CFG_HEIGHT: img_h = val;
        default: ;
      endcase
      restart_frame();
    endfunction

    function void note_word(logic req, pixel_t px);
      int unsigned    w, h, total, lag, fed, pos, r, c, ch;
      pixel_t         centre, lo, hi, nb, res;
      filtered_word_t fw;
      w = (img_w < MIN_SIZE) ? MIN_SIZE : (img_w > MAX_WIDTH) ? MAX_WIDTH : img_w;
      h = (img_h < MIN_SIZE) ? MIN_SIZE : img_h;
      total = w * h;
      lag   = HALF * w + HALF;
      if (req == REQ_PIXEL) begin
        // a pixel after a complete frame opens the next one
        if (in_line >= h) begin
          in_col   = 0;
          in_line  = 0;
          out_col  = 0;
          out_line = 0;
        end
        line_mem[in_line % WINDOW_SIZE][in_col] = px;
        in_col++;
        if (in_col >= w) begin
          in_col = 0;
          in_line++;
        end
      end
      fed = in_line * w + in_col;
      pos = out_line * w + out_col;
      if ((in_line >= h) ? (pos >= total) : (pos + lag >= fed)) return;
      centre = line_mem[out_line % WINDOW_SIZE][out_col];
      res    = centre;
      if (out_line >= HALF && out_line + HALF < h &&
          out_col >= HALF && out_col + HALF < w) begin
        lo = '1;
        hi = '0;
        for (r = 0; r < WINDOW_SIZE; r++) begin
          for (c = 0; c < WINDOW_SIZE; c++) begin
            if (r != HALF || c != HALF) begin
              nb = line_mem[(out_line - HALF + r) % WINDOW_SIZE][out_col - HALF + c];
              for (ch = 0; ch < NUM_CHAN; ch++) begin
                if (nb[ch] < lo[ch]) lo[ch] = nb[ch];
                if (nb[ch] > hi[ch]) hi[ch] = nb[ch];
              end
            end
          end
        end
        for (ch = 0; ch < NUM_CHAN; ch++) begin
          if (centre[ch] < lo[ch]) res[ch] = lo[ch];
          else if (centre[ch] > hi[ch]) res[ch] = hi[ch];
        end
      end
      fw.pix  = res;
      fw.last = (pos + 1 == total);
      filtered_due.push_back(fw);
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_line++;
      end
    endfunction

    function void check_word(pixel_t got, logic last);
      filtered_word_t fw;
      int unsigned    ch;
      if (filtered_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected word %h end_of_frame %b", $time, got, last);
        return;
      end
      fw = filtered_due.pop_front();
      for (ch = 0; ch < NUM_CHAN; ch++) begin
        if (got[ch] !== fw.pix[ch]) begin
          errors++;
          $display("%0t: out_chan%0d expected %h actual %h", $time, ch, fw.pix[ch],
                   got[ch]);
        end
      end
      if (last !== fw.last) begin
        errors++;
        $display("%0t: end_of_frame expected %b actual %b", $time, fw.last, last);
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 req_type_i;
  logic [CHAN_W-1:0]    chan0_i, chan1_i, chan2_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [CHAN_W-1:0]    out_chan0_o, out_chan1_o, out_chan2_o;
  logic                 end_of_frame_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_data_i;

  smoothing_tracker tracker;
  int unsigned      gap_pct = 0;
  int unsigned      stall_pct = 0;
  int unsigned      words_sent = 0;
  int unsigned      cycles = 0;
  int unsigned      cur_w, cur_h;
  logic [7:0]       band_base = 8'd0;

  conservative_smoothing_filter_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .chan0_i        (chan0_i),
    .chan1_i        (chan1_i),
    .chan2_i        (chan2_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_chan0_o    (out_chan0_o),
    .out_chan1_o    (out_chan1_o),
    .out_chan2_o    (out_chan2_o),
    .end_of_frame_o (end_of_frame_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) tracker.note_word(req_type_i,
                                                       {chan2_i, chan1_i, chan0_i});
      if (out_valid_o && !out_stall_i) tracker.check_word(
          {out_chan2_o, out_chan1_o, out_chan0_o}, end_of_frame_o);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic pixel_t random_pixel(fill_e fill);
    pixel_t      p;
    int unsigned ch;
    for (ch = 0; ch < NUM_CHAN; ch++) begin
      case (fill)
        FILL_BAND: p[ch] = 8'(band_base + $urandom_range(6));
        FILL_RAIL: p[ch] = $urandom_range(1) ? 8'hFF : 8'h00;
        default:   p[ch] = 8'($urandom_range(255));
      endcase
    end
    return p;
  endfunction

  task automatic put_word(input logic req, input pixel_t px);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    chan0_i    <= px[0];
    chan1_i    <= px[1];
    chan2_i    <= px[2];
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // stray padding inside a frame is ignored by the block and not counted
  task automatic send_pixels(input int unsigned count, input fill_e fill);
    int unsigned i;
    band_base = 8'($urandom_range(249));
    for (i = 0; i < count; i++) begin
      if ($urandom_range(19) == 0) put_word(REQ_PAD, random_pixel(FILL_ANY));
      put_word(REQ_PIXEL, random_pixel(fill));
      words_sent++;
    end
  endtask

  task automatic send_pads(input int unsigned count);
    int unsigned i;
    for (i = 0; i < count; i++) begin
      put_word(REQ_PAD, random_pixel(FILL_ANY));
      words_sent++;
    end
  endtask

  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.filtered_due.size() != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_size(input logic [CFG_W-1:0] wv, input logic [CFG_W-1:0] hv);
    wait_quiet();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_WIDTH;
    cfg_data_i  <= wv;
    @(posedge clk_i);
    tracker.write_reg(CFG_WIDTH, wv);
    cfg_index_i <= CFG_HEIGHT;
    cfg_data_i  <= hv;
    @(posedge clk_i);
    tracker.write_reg(CFG_HEIGHT, hv);
    cfg_we_i <= 1'b0;
    cur_w = (wv < MIN_SIZE) ? MIN_SIZE : (wv > MAX_WIDTH) ? MAX_WIDTH : wv;
    cur_h = (hv < MIN_SIZE) ? MIN_SIZE : hv;
  endtask

  initial begin
    pixel_t      px;
    int unsigned k, target, pick, frame_px;
    fill_e       fill;
    tracker     = new();
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    req_type_i  <= REQ_PIXEL;
    chan0_i     <= '0;
    chan1_i     <= '0;
    chan2_i     <= '0;
    out_stall_i <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= CFG_WIDTH;
    cfg_data_i  <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // padding with nothing pending, then a few pixels at the reset size
    put_word(REQ_PAD, random_pixel(FILL_ANY));
    send_pixels(2, FILL_ANY);

    // undersized registers clamp to a 3x3 frame; one interior pixel
    write_size(12'd2, 12'd0);
    for (k = 0; k < 9; k++) begin
      px[0] = (k == 4) ? 8'd0 : 8'(200 + k);
      px[1] = (k == 4) ? 8'd255 : 8'(10 * k + 10);
      px[2] = (k == 4) ? 8'd50 : ((k == 0) ? 8'd0 : 8'd255);
      put_word(REQ_PIXEL, px);
      if (k == 3) put_word(REQ_PAD, px);
      words_sent++;
    end
    send_pads(5);
    // partial drain, then a new frame drops the rest
    send_pixels(9, FILL_RAIL);
    send_pads(2);
    send_pixels(9, FILL_RAIL);
    send_pads(4);

    // largest sizes, partial frames only
    write_size(12'd2048, 12'd4095);
    send_pixels(2060, FILL_ANY);
    write_size(12'd4095, 12'd2048);
    send_pixels(2056, FILL_BAND);
    write_size(12'd0, 12'd4095);
    send_pixels(30, FILL_ANY);
    write_size(12'd3, 12'd3);

    target = words_sent + RANDOM_WORDS;
    while (words_sent < target) begin
      case ((words_sent / 200) % 4)
        0: begin
          gap_pct   = 0;
          stall_pct = 0;
        end
        1: begin
          gap_pct   = 45;
          stall_pct = 0;
        end
        2: begin
          gap_pct   = 0;
          stall_pct = 45;
        end
        default: begin
          gap_pct   = 15;
          stall_pct = 15;
        end
      endcase
      pick = $urandom_range(19);
      if (pick < 2) write_size(12'($urandom_range(3, 12)), 12'($urandom_range(3, 8)));
      else if (pick == 2) write_size(12'($urandom_range(2)), 12'($urandom_range(2)));
      frame_px = cur_w * cur_h;
      fill     = fill_e'($urandom_range(2));
      if ($urandom_range(9) == 0) begin
        // abandoned frame, then a restart by register write
        send_pixels($urandom_range(1, frame_px - 1), fill);
        write_size(12'($urandom_range(3, 12)), 12'($urandom_range(3, 8)));
      end else begin
        send_pixels(frame_px, fill);
        pick = $urandom_range(9);
        if (pick < 6) send_pads(cur_w + 1 + $urandom_range(2));
        else if (pick < 8) send_pads($urandom_range(cur_w));
      end
    end
    send_pads(cur_w + 1);
    wait_quiet();

    if (tracker.errors == 0 && tracker.filtered_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
